### design/lcd_escape_command_sequencer_macros.svh
// Assertion macros used by the checker of the LCD escape command sequencer.
`ifndef LCD_ESCAPE_COMMAND_SEQUENCER_MACROS_SVH
`define LCD_ESCAPE_COMMAND_SEQUENCER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LCDSEQ_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LCDSEQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/lcdseq_pkg.sv
// Types, constants and the access generator of the LCD escape command sequencer.
package lcdseq_pkg;

    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 1;
    localparam int DELAY_W     = 14;
    localparam int STEP_W      = 3;

    localparam logic [CFG_INDEX_W-1:0] CFG_TWO_LINE   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LARGE_FONT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CURSOR_ON  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLINK_ON   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_PASS_ALL   = 3'd4;

    localparam logic [7:0] CHR_ESC       = 8'h5C;
    localparam logic [7:0] CHR_RESET     = 8'h52;
    localparam logic [7:0] CHR_BACKSPACE = 8'h62;
    localparam logic [7:0] CHR_CLEAR     = 8'h66;
    localparam logic [7:0] CHR_NEWLINE   = 8'h6E;
    localparam logic [7:0] CHR_RETURN    = 8'h72;
    localparam logic [7:0] CHR_HOME      = 8'h76;
    localparam logic [7:0] CODE_RESET     = 8'h00;
    localparam logic [7:0] CODE_BACKSPACE = 8'h01;
    localparam logic [7:0] CODE_CLEAR     = 8'h02;
    localparam logic [7:0] CODE_NEWLINE   = 8'h03;
    localparam logic [7:0] CODE_RETURN    = 8'h04;
    localparam logic [7:0] CODE_HOME      = 8'h05;
    localparam logic [7:0] PRINT_LO       = 8'h20;
    localparam logic [7:0] PRINT_HI       = 8'h7E;

    localparam logic [7:0] INSTR_FUNCTION_SET = 8'h30;
    localparam logic [7:0] INSTR_DISPLAY_OFF  = 8'h08;
    localparam logic [7:0] INSTR_DISPLAY_ON   = 8'h0C;
    localparam logic [7:0] INSTR_ENTRY_MODE   = 8'h06;
    localparam logic [7:0] INSTR_CLEAR        = 8'h01;
    localparam logic [7:0] INSTR_SHIFT_LEFT   = 8'h10;
    localparam logic [7:0] INSTR_LINE_TWO     = 8'hC0;
    localparam logic [7:0] INSTR_SET_ADDR     = 8'h80;
    localparam logic [7:0] INSTR_HOME         = 8'h02;
    localparam logic [7:0] ADDR_MASK          = 8'h3F;

    localparam logic [DELAY_W-1:0] DLY_POWER_UP = 14'd10000;
    localparam logic [DELAY_W-1:0] DLY_INIT     = 14'd1000;
    localparam logic [DELAY_W-1:0] DLY_CMD      = 14'd40;
    localparam logic [DELAY_W-1:0] DLY_LONG     = 14'd2040;
    localparam logic [DELAY_W-1:0] DLY_NONE     = 14'd0;

    localparam logic [STEP_W-1:0] RESET_LAST_STEP = 3'd6;

    typedef enum logic [2:0] {
        ACT_RESET,
        ACT_BACKSPACE,
        ACT_CLEAR,
        ACT_NEWLINE,
        ACT_READ,
        ACT_HOME,
        ACT_DATA,
        ACT_ADDR
    } t_action;

    typedef struct packed {
        t_action    action;
        logic [7:0] data;
    } t_entry;

    typedef struct packed {
        logic two_line;
        logic large_font;
        logic cursor_on;
        logic blink_on;
        logic pass_all;
    } t_cfg;

    typedef struct packed {
        logic               is_read;
        logic               reg_select;
        logic [7:0]         bus_data;
        logic [DELAY_W-1:0] delay_us;
        logic               last;
    } t_access;

    function automatic t_access access_of(input t_entry ent, input logic [STEP_W-1:0] step,
                                          input t_cfg cfg);
        t_access    acc;
        logic [7:0] fs;
        fs = INSTR_FUNCTION_SET | {4'b0, cfg.two_line, cfg.large_font, 2'b0};
        acc.is_read    = 1'b0;
        acc.reg_select = 1'b0;
        acc.bus_data   = ent.data;
        acc.delay_us   = DLY_CMD;
        acc.last       = 1'b1;
        unique case (ent.action)
            ACT_RESET: begin
                acc.last = (step == RESET_LAST_STEP);
                case (step) inside
                    3'd0: begin
                        acc.bus_data = fs;
                        acc.delay_us = DLY_POWER_UP;
                    end
                    3'd1, 3'd2: begin
                        acc.bus_data = fs;
                        acc.delay_us = DLY_INIT;
                    end
                    3'd3: begin
                        acc.bus_data = INSTR_DISPLAY_OFF;
                        acc.delay_us = DLY_INIT;
                    end
                    3'd4: begin
                        acc.bus_data = INSTR_DISPLAY_ON | {6'b0, cfg.cursor_on, cfg.blink_on};
                        acc.delay_us = DLY_INIT;
                    end
                    3'd5: begin
                        acc.bus_data = INSTR_ENTRY_MODE;
                        acc.delay_us = DLY_INIT;
                    end
                    default: begin
                        acc.bus_data = INSTR_CLEAR;
                        acc.delay_us = DLY_LONG;
                    end
                endcase
            end
            ACT_BACKSPACE: acc.bus_data = INSTR_SHIFT_LEFT;
            ACT_CLEAR: begin
                acc.bus_data = INSTR_CLEAR;
                acc.delay_us = DLY_LONG;
            end
            ACT_NEWLINE: acc.bus_data = INSTR_LINE_TWO;
            ACT_READ: begin
                acc.is_read  = 1'b1;
                acc.bus_data = 8'h00;
                acc.delay_us = DLY_NONE;
            end
            ACT_HOME: begin
                acc.bus_data = INSTR_HOME;
                acc.delay_us = DLY_LONG;
            end
            ACT_DATA: acc.reg_select = 1'b1;
            ACT_ADDR: acc.bus_data = INSTR_SET_ADDR | (ent.data & ADDR_MASK);
        endcase
        return acc;
    endfunction

endpackage

### design/lcdseq_fifo.sv
// Short queue of decoded actions between the front and the back of the sequencer.
module lcdseq_fifo #(
    parameter int DEPTH = lcdseq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lcdseq_pkg::t_entry   i_entry,
    input  logic                 i_push,
    input  logic                 i_pop,
    output lcdseq_pkg::t_entry   o_head,
    output logic                 o_empty,
    output logic                 o_full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    lcdseq_pkg::t_entry r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr;
    logic [PTR_W-1:0]   r_rd;
    logic [CNT_W-1:0]   r_count;
    logic [PTR_W-1:0]   n_wr;
    logic [PTR_W-1:0]   n_rd;
    logic [CNT_W-1:0]   n_count;
    logic               do_push;
    logic               do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule

### design/lcdseq_front.sv
// Front end: accepts input bytes, tracks escape and readback state, and queues actions.
module lcdseq_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic                   i_command,
    input  logic [7:0]             i_value,
    input  lcdseq_pkg::t_cfg       i_cfg,
    input  logic                   i_full,
    output logic                   o_push,
    output lcdseq_pkg::t_entry     o_entry
);

    logic r_escape_pending;
    logic r_awaiting_readback;
    logic n_escape_pending;
    logic n_awaiting_readback;
    logic accept;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_escape_pending    = r_escape_pending;
        n_awaiting_readback = r_awaiting_readback;
        o_push              = 1'b0;
        o_entry.action      = lcdseq_pkg::ACT_DATA;
        o_entry.data        = i_value;
        if (accept) begin
            if (i_command) begin
                if (r_awaiting_readback) begin
                    n_awaiting_readback = 1'b0;
                    o_push              = 1'b1;
                    o_entry.action      = lcdseq_pkg::ACT_ADDR;
                end
            end else if (!r_awaiting_readback) begin
                if (r_escape_pending) begin
                    n_escape_pending = 1'b0;
                    unique case (i_value) inside
                        lcdseq_pkg::CHR_RESET, lcdseq_pkg::CODE_RESET: begin
                            o_push         = 1'b1;
                            o_entry.action = lcdseq_pkg::ACT_RESET;
                        end
                        lcdseq_pkg::CHR_BACKSPACE, lcdseq_pkg::CODE_BACKSPACE: begin
                            o_push         = 1'b1;
                            o_entry.action = lcdseq_pkg::ACT_BACKSPACE;
                        end
                        lcdseq_pkg::CHR_CLEAR, lcdseq_pkg::CODE_CLEAR: begin
                            o_push         = 1'b1;
                            o_entry.action = lcdseq_pkg::ACT_CLEAR;
                        end
                        lcdseq_pkg::CHR_NEWLINE, lcdseq_pkg::CODE_NEWLINE: begin
                            o_push         = i_cfg.two_line;
                            o_entry.action = lcdseq_pkg::ACT_NEWLINE;
                        end
                        lcdseq_pkg::CHR_RETURN, lcdseq_pkg::CODE_RETURN: begin
                            o_push              = 1'b1;
                            o_entry.action      = lcdseq_pkg::ACT_READ;
                            n_awaiting_readback = 1'b1;
                        end
                        lcdseq_pkg::CHR_HOME, lcdseq_pkg::CODE_HOME: begin
                            o_push         = 1'b1;
                            o_entry.action = lcdseq_pkg::ACT_HOME;
                        end
                        lcdseq_pkg::CHR_ESC: begin
                            o_push = 1'b1;
                        end
                        default: begin
                            o_push = 1'b0;
                        end
                    endcase
                end else if (i_value == lcdseq_pkg::CHR_ESC) begin
                    n_escape_pending = 1'b1;
                end else if (i_cfg.pass_all || (i_value >= lcdseq_pkg::PRINT_LO &&
                                                 i_value <= lcdseq_pkg::PRINT_HI)) begin
                    o_push = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_escape_pending    <= 1'b0;
            r_awaiting_readback <= 1'b0;
        end else begin
            r_escape_pending    <= n_escape_pending;
            r_awaiting_readback <= n_awaiting_readback;
        end
    end

endmodule

### design/lcdseq_back.sv
// Back end: steps through the accesses of each queued action into the output register.
module lcdseq_back (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  lcdseq_pkg::t_entry                    i_head,
    input  logic                                  i_empty,
    input  lcdseq_pkg::t_cfg                      i_cfg,
    output logic                                  o_pop,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic                                  o_is_read,
    output logic                                  o_reg_select,
    output logic [7:0]                            o_bus_data,
    output logic [lcdseq_pkg::DELAY_W-1:0]        o_delay_us,
    output logic                                  o_last
);

    logic                            r_valid;
    logic [lcdseq_pkg::STEP_W-1:0]   r_step;
    lcdseq_pkg::t_access             r_acc;
    logic                            n_valid;
    logic [lcdseq_pkg::STEP_W-1:0]   n_step;
    lcdseq_pkg::t_access             acc;
    logic                            load;

    assign acc   = lcdseq_pkg::access_of(i_head, r_step, i_cfg);
    assign load  = !i_empty && (!r_valid || i_ready);
    assign o_pop = load && acc.last;

    always_comb begin
        n_valid = r_valid;
        n_step  = r_step;
        if (load) begin
            n_valid = 1'b1;
            n_step  = acc.last ? '0 : r_step + 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_step  <= '0;
        end else begin
            r_valid <= n_valid;
            r_step  <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_acc <= acc;
        end
    end

    assign o_valid      = r_valid;
    assign o_is_read    = r_acc.is_read;
    assign o_reg_select = r_acc.reg_select;
    assign o_bus_data   = r_acc.bus_data;
    assign o_delay_us   = r_acc.delay_us;
    assign o_last       = r_acc.last;

endmodule

### design/lcd_escape_command_sequencer.sv
// Top level of the LCD escape command sequencer: configuration, front, queue and back.
//
//   port group   direction  handshake          payload
//   input        in         i_valid/o_ready    i_command, i_value
//   output       out        o_valid/i_ready    o_is_read, o_reg_select, o_bus_data,
//                                              o_delay_us, o_last
//   config       in         i_cfg_we           i_cfg_index, i_cfg_data
//
// An input transaction is taken whenever the action queue has room.
// The back end emits one access a cycle unless stalled: one for most actions, seven for reset.
// The back end's step counter and output register set the sustained rate of one access a cycle.
// Reset is synchronous and clears the configuration to its defaults, the state and the queue.
// A stalled output holds its transaction; the queue then fills and o_ready drops.
module lcd_escape_command_sequencer #(
    parameter int QUEUE_DEPTH = lcdseq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic                                  i_command,
    input  logic [7:0]                            i_value,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic                                  o_is_read,
    output logic                                  o_reg_select,
    output logic [7:0]                            o_bus_data,
    output logic [lcdseq_pkg::DELAY_W-1:0]        o_delay_us,
    output logic                                  o_last,
    input  logic                                  i_cfg_we,
    input  logic [lcdseq_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [lcdseq_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    lcdseq_pkg::t_cfg       r_cfg;
    lcdseq_pkg::t_cfg       n_cfg;
    lcdseq_pkg::t_entry     push_entry;
    lcdseq_pkg::t_entry     head;
    logic                   push;
    logic                   full;
    logic                   empty;
    logic                   pop;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                lcdseq_pkg::CFG_TWO_LINE:   n_cfg.two_line   = i_cfg_data[0];
                lcdseq_pkg::CFG_LARGE_FONT: n_cfg.large_font = i_cfg_data[0];
                lcdseq_pkg::CFG_CURSOR_ON:  n_cfg.cursor_on  = i_cfg_data[0];
                lcdseq_pkg::CFG_BLINK_ON:   n_cfg.blink_on   = i_cfg_data[0];
                lcdseq_pkg::CFG_PASS_ALL:   n_cfg.pass_all   = i_cfg_data[0];
                default:                    n_cfg            = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{two_line: 1'b1, large_font: 1'b0, cursor_on: 1'b0,
                       blink_on: 1'b0, pass_all: 1'b0};
        end else begin
            r_cfg <= n_cfg;
        end
    end

    lcdseq_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_command (i_command),
        .i_value   (i_value),
        .i_cfg     (r_cfg),
        .i_full    (full),
        .o_push    (push),
        .o_entry   (push_entry)
    );

    lcdseq_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_entry (push_entry),
        .i_push  (push),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (empty),
        .o_full  (full)
    );

    lcdseq_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_empty      (empty),
        .i_cfg        (r_cfg),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_is_read    (o_is_read),
        .o_reg_select (o_reg_select),
        .o_bus_data   (o_bus_data),
        .o_delay_us   (o_delay_us),
        .o_last       (o_last)
    );

endmodule

### design/lcdseq_checker.sv
// Port-level checker of the LCD escape command sequencer and its bind statement.
`include "lcd_escape_command_sequencer_macros.svh"

module lcdseq_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_valid,
    input logic                                  o_ready,
    input logic                                  i_command,
    input logic [7:0]                            i_value,
    input logic                                  o_valid,
    input logic                                  i_ready,
    input logic                                  o_is_read,
    input logic                                  o_reg_select,
    input logic [7:0]                            o_bus_data,
    input logic [lcdseq_pkg::DELAY_W-1:0]        o_delay_us,
    input logic                                  o_last
);

    logic                             in_stall;
    logic [8:0]                       in_payload;
    logic                             out_stall;
    logic [lcdseq_pkg::DELAY_W+10:0]  out_payload;
    logic                             out_read;
    logic                             read_ok;
    logic                             out_data;
    logic                             data_ok;
    logic                             out_power_up;
    logic                             power_up_ok;

    assign in_stall     = i_valid && !o_ready;
    assign in_payload   = {i_command, i_value};
    assign out_stall    = o_valid && !i_ready;
    assign out_payload  = {o_is_read, o_reg_select, o_bus_data, o_delay_us, o_last};
    assign out_read     = o_valid && o_is_read;
    assign read_ok      = !o_reg_select && o_bus_data == 8'h00 &&
                          o_delay_us == lcdseq_pkg::DLY_NONE && o_last;
    assign out_data     = o_valid && o_reg_select;
    assign data_ok      = !o_is_read && o_delay_us == lcdseq_pkg::DLY_CMD && o_last;
    assign out_power_up = o_valid && o_delay_us == lcdseq_pkg::DLY_POWER_UP;
    assign power_up_ok  = !o_last && !o_reg_select && o_bus_data[7:4] == 4'h3;

    `LCDSEQ_ASSERT_NEXT(a_in_hold, in_stall, i_valid && $stable(in_payload), "stalled input changed")

    `LCDSEQ_ASSERT_NEXT(a_out_hold, out_stall, o_valid && $stable(out_payload), "stalled output changed")

    `LCDSEQ_ASSERT_IMPLY(a_read_shape, out_read, read_ok, "malformed read request")

    `LCDSEQ_ASSERT_IMPLY(a_data_shape, out_data, data_ok, "malformed data write")

    `LCDSEQ_ASSERT_IMPLY(a_power_up, out_power_up, power_up_ok, "bad opening function set")

endmodule

bind lcd_escape_command_sequencer lcdseq_checker u_checker (.*);
